@@ hdl/hep_pkg.sv @@
`timescale 1ns / 1ps
package hep_pkg;
    localparam int DEF_COUNT_BITS = 24;
    localparam int NUM_BINS       = 256;
    localparam int BIN_BITS       = 8;
    localparam int PIX_BITS       = 8;
    localparam int KIND_BITS      = 2;
    localparam int FULL_SCALE     = 255;

    localparam logic [KIND_BITS-1:0] KIND_CLEAR   = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_COLLECT = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_MAP     = 2'd2;
    localparam logic [KIND_BITS-1:0] KIND_UNUSED  = 2'd3;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_COLLECT = 2'd1,
        OP_MAP     = 2'd2
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [PIX_BITS-1:0] pix;
    } t_cmd;
endpackage

@@ hdl/hep_front.sv @@
`timescale 1ns / 1ps
// Classifies items and queues commands for the back end. Kind 3 is dropped.
module hep_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_kind,
    input  logic [7:0]            i_pixel_value,
    output logic                  o_cmd_valid,
    input  logic                  i_cmd_take,
    output hep_pkg::t_cmd         o_cmd
);
    import hep_pkg::*;

    localparam int QDEPTH = 2;

    t_cmd       r_q [QDEPTH];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_push, w_pop;
    t_cmd       w_cmd;

    assign o_stall     = (r_cnt == 2'(QDEPTH));
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_pop       = o_cmd_valid && i_cmd_take;
    assign w_push      = i_valid && !o_stall && (i_kind != KIND_UNUSED);

    always_comb begin
        w_cmd.pix = i_pixel_value;
        unique case (i_kind)
            KIND_CLEAR:   w_cmd.op = OP_CLEAR;
            KIND_COLLECT: w_cmd.op = OP_COLLECT;
            default:      w_cmd.op = OP_MAP;
        endcase
        n_wp  = r_wp ^ w_push;
        n_rp  = r_rp ^ w_pop;
        n_cnt = r_cnt + {1'b0, w_push} - {1'b0, w_pop};
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end
endmodule

@@ hdl/hep_back.sv @@
`timescale 1ns / 1ps
// Executes commands: bin clear, histogram update, prefix build, and serial divide.
module hep_back #(
    parameter int COUNT_BITS = hep_pkg::DEF_COUNT_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_take,
    input  hep_pkg::t_cmd i_cmd,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [7:0]    o_mapped_pixel,
    output logic          o_no_pixels_flag
);
    import hep_pkg::*;

    localparam int NB = COUNT_BITS + 8;   // width of 255*cum
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CLR   = 4'd1;
    localparam logic [3:0] S_CRD   = 4'd2;
    localparam logic [3:0] S_CWR   = 4'd3;
    localparam logic [3:0] S_BRD   = 4'd4;
    localparam logic [3:0] S_BACC  = 4'd5;
    localparam logic [3:0] S_MRD   = 4'd6;
    localparam logic [3:0] S_MMUL  = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [COUNT_BITS-1:0] r_bins [NUM_BINS];
    logic [COUNT_BITS-1:0] r_cums [NUM_BINS];
    logic [COUNT_BITS-1:0] r_bin_rd, r_cum_rd;

    logic [3:0]            r_st;
    logic [BIN_BITS-1:0]   r_idx;
    logic [COUNT_BITS-1:0] r_total, r_acc;
    logic                  r_ready;
    logic [NB-1:0]         r_num;
    logic [COUNT_BITS:0]   r_rem;
    logic [5:0]            r_bit;
    logic [7:0]            r_res;
    logic                  r_flag;
    logic                  r_ovalid;

    logic [COUNT_BITS:0]   w_sum, w_shift;
    logic [COUNT_BITS-1:0] w_acc_sat;

    assign o_cmd_take      = (r_st == S_IDLE) && i_cmd_valid && !r_ovalid;
    assign o_valid         = r_ovalid;
    assign o_mapped_pixel  = r_res;
    assign o_no_pixels_flag = r_flag;

    assign w_sum     = {1'b0, r_acc} + {1'b0, r_bin_rd};
    assign w_acc_sat = w_sum[COUNT_BITS] ? CMAX : w_sum[COUNT_BITS-1:0];
    assign w_shift   = {r_rem[COUNT_BITS-1:0], r_num[NB-1]};

    // memory ports
    always_ff @(posedge i_clk) begin
        r_bin_rd <= r_bins[r_idx];
        r_cum_rd <= r_cums[r_idx];
        if (r_st == S_CLR) begin
            r_bins[r_idx] <= '0;
        end else if (r_st == S_CWR) begin
            r_bins[r_idx] <= (r_bin_rd == CMAX) ? CMAX : r_bin_rd + 1'b1;
        end
        if (r_st == S_BACC) begin
            r_cums[r_idx] <= w_acc_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_CLR;
            r_idx    <= '0;
            r_total  <= '0;
            r_ready  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_st)
                S_IDLE: begin
                    if (o_cmd_take) begin
                        unique case (i_cmd.op)
                            OP_CLEAR: begin
                                r_idx   <= '0;
                                r_total <= '0;
                                r_ready <= 1'b0;
                                r_st    <= S_CLR;
                            end
                            OP_COLLECT: begin
                                r_idx   <= i_cmd.pix;
                                r_ready <= 1'b0;
                                if (r_total != CMAX) begin
                                    r_total <= r_total + 1'b1;
                                end
                                r_st <= S_CRD;
                            end
                            default: begin
                                if (r_total == '0) begin
                                    r_res    <= '0;
                                    r_flag   <= 1'b1;
                                    r_ovalid <= 1'b1;
                                end else if (r_ready) begin
                                    r_idx <= i_cmd.pix;
                                    r_st  <= S_MRD;
                                end else begin
                                    r_res <= i_cmd.pix;   // hold pixel during build
                                    r_idx <= '0;
                                    r_acc <= '0;
                                    r_st  <= S_BRD;
                                end
                            end
                        endcase
                    end
                end
                S_CLR: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == BIN_BITS'(NUM_BINS - 1)) begin
                        r_st <= S_IDLE;
                    end
                end
                S_CRD: r_st <= S_CWR;
                S_CWR: r_st <= S_IDLE;
                S_BRD: r_st <= S_BACC;
                S_BACC: begin
                    r_acc <= w_acc_sat;
                    if (r_idx == BIN_BITS'(NUM_BINS - 1)) begin
                        r_ready <= 1'b1;
                        r_idx   <= r_res;
                        r_st    <= S_MRD;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                        r_st  <= S_BRD;
                    end
                end
                S_MRD: r_st <= S_MMUL;
                S_MMUL: begin
                    r_num <= NB'(r_cum_rd) * NB'(FULL_SCALE);
                    r_rem <= '0;
                    r_bit <= 6'(NB);
                    r_st  <= S_DIV;
                end
                S_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    if (w_shift >= {1'b0, r_total}) begin
                        r_rem <= w_shift - {1'b0, r_total};
                        r_num <= {r_num[NB-2:0], 1'b1};
                    end else begin
                        r_rem <= w_shift;
                        r_num <= {r_num[NB-2:0], 1'b0};
                    end
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == 6'd1) begin
                        r_st <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_res    <= (r_num > NB'(FULL_SCALE)) ? 8'(FULL_SCALE) : r_num[7:0];
                    r_flag   <= 1'b0;
                    r_ovalid <= 1'b1;
                    r_st     <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

@@ hdl/histogram_equalize_pixels.sv @@
`timescale 1ns / 1ps
// Per command: collect increments one bin, clear zeroes all bins, and map reads the
// prefix sum, scales it by 255 and divides by the total (result 0, flag set, on
// an empty histogram); the first map after a collect builds the prefix sums first.
// One item at a time in the back end (single memory port, bit-serial divider); a
// two-item queue lets the front accept ahead of it. Reset is synchronous and starts
// a clearing pass over the bins, while the front queues up to two items.
module histogram_equalize_pixels #(
    parameter int COUNT_BITS = hep_pkg::DEF_COUNT_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_kind,
    input  logic [7:0] i_pixel_value,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_mapped_pixel,
    output logic       o_no_pixels_flag
);
    import hep_pkg::*;

    logic w_cmd_valid, w_cmd_take;
    t_cmd w_cmd;

    hep_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_kind, .i_pixel_value,
        .o_cmd_valid(w_cmd_valid), .i_cmd_take(w_cmd_take), .o_cmd(w_cmd)
    );

    hep_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk, .i_rst_n,
        .i_cmd_valid(w_cmd_valid), .o_cmd_take(w_cmd_take), .i_cmd(w_cmd),
        .o_valid, .i_stall, .o_mapped_pixel, .o_no_pixels_flag
    );
endmodule
